FILE: rtl/kvc_pkg.sv
// kvc_pkg: shared types and constants of the key/value cache
// no dependencies; used by the interfaces and every module of the block
package kvc_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic signed [31:0] word_t;

  localparam word_t MISS_VALUE = -32'sd1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic cmp_en;
  } scan_ctl_t;

  typedef struct packed {
    logic found;
    logic old_found;
    logic free_found;
  } scan_res_t;

endpackage

FILE: rtl/kvc_if.sv
// kvc_if: valid/ready channels of the key/value cache
// depends on kvc_pkg for payload types
interface kvc_req_if;
  import kvc_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  word_t key;
  word_t write_value;
  modport source(output valid, cmd, key, write_value, input ready);
  modport sink(input valid, cmd, key, write_value, output ready);
endinterface

interface kvc_rsp_if;
  import kvc_pkg::*;
  logic  valid;
  logic  ready;
  logic  hit;
  word_t read_value;
  modport source(output valid, hit, read_value, input ready);
  modport sink(input valid, hit, read_value, output ready);
endinterface

interface kvc_cfg_if;
  import kvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: rtl/key_value_cache_lru_on_write_core.sv
// key_value_cache_lru_on_write_core: fully associative key/value cache, lru on write
// depends on kvc_pkg, kvc_if, kvc_store and kvc_scan
//
// channels: req (cmd, key, write_value), rsp (hit, read_value), cfg (capacity).
// all are valid/ready; a transfer happens on a rising edge with both high.
// a get returns one rsp item: hit and the stored value, or hit low and -1.
// a set returns nothing; it overwrites a present key and makes it newest,
// or inserts the key, evicting the least recently written entry when the
// occupancy has reached the capacity (0 acts as 1, above DEPTH as DEPTH).
// cfg is always ready and must only be written while the block is idle.
// each item runs from its transfer through the scan, drain and update states
// and back to idle before the earliest next transfer; req.ready is low in all
// three: the single compare unit walks the key memory one entry per cycle
// through its one read port, then the drain state and the update state follow.
// a get result is registered in the update state.
// rsp is an output register: a new request is taken while a result waits;
// a following get holds in its update cycle until the old result is taken.
// reset (rst, synchronous) empties the cache and sets capacity to 16.
module key_value_cache_lru_on_write_core #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  kvc_req_if.sink   req,
  kvc_rsp_if.source rsp,
  kvc_cfg_if.sink   cfg
);
  import kvc_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD
  } state_t;

  state_t           state;
  logic [CAP_W-1:0] capacity;
  cmd_t             cmd_q;
  word_t            key_q;
  word_t            val_q;
  logic [IW-1:0]    idx;
  logic             cmp_en_q;
  logic [IW-1:0]    cmp_idx_q;
  logic [DEPTH-1:0] valid;
  logic [IW-1:0]    rank [DEPTH];
  logic [CW-1:0]    occ;
  logic             rsp_valid;
  logic             rsp_hit;
  word_t            rsp_data;

  word_t         rd_key;
  word_t         rd_val;
  scan_ctl_t     sctl;
  scan_res_t     res;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] hit_rank;
  word_t         hit_val;
  logic [IW-1:0] old_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] old_rank;
  logic [IW-1:0] slot;
  logic [31:0]   cap_w;
  logic [31:0]   eff_cap;
  logic          full;
  logic          accept;
  logic          wr_en;
  logic          rsp_load;

  assign req.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_data;

  assign accept   = req.valid && req.ready;
  assign wr_en    = (state == ST_UPD) && (cmd_q == CMD_SET);
  assign rsp_load = (state == ST_UPD) && (cmd_q == CMD_GET) && (!rsp_valid || rsp.ready);

  assign cap_w   = 32'(capacity);
  assign eff_cap = (cap_w == 32'd0) ? 32'd1 :
                   ((cap_w > 32'(DEPTH)) ? 32'(DEPTH) : cap_w);
  assign full    = 32'(occ) >= eff_cap;

  assign old_rank = IW'(occ - CW'(1));
  assign slot     = res.found ? hit_idx : (full ? old_idx : free_idx);

  assign sctl.clear  = accept;
  assign sctl.cmp_en = cmp_en_q;

  kvc_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wkey  (key_q),
    .wval  (val_q),
    .raddr (idx),
    .rkey  (rd_key),
    .rval  (rd_val)
  );

  kvc_scan #(.DEPTH(DEPTH)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sctl),
    .idx      (cmp_idx_q),
    .key      (key_q),
    .rd_key   (rd_key),
    .rd_val   (rd_val),
    .valid_at (valid[cmp_idx_q]),
    .rank_at  (rank[cmp_idx_q]),
    .old_rank (old_rank),
    .res      (res),
    .hit_idx  (hit_idx),
    .hit_rank (hit_rank),
    .hit_val  (hit_val),
    .old_idx  (old_idx),
    .free_idx (free_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_RESET;
      cmp_en_q  <= 1'b0;
      valid     <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      cmp_en_q  <= (state == ST_SCAN);
      cmp_idx_q <= idx;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_hit   <= res.found;
        rsp_data  <= res.found ? hit_val : MISS_VALUE;
      end else if (rsp.valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.cmd;
            key_q <= req.key;
            val_q <= req.write_value;
            idx   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx <= IW'(idx + IW'(1));
          if (idx == LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (cmd_q == CMD_GET) begin
            if (rsp_load) begin
              state <= ST_IDLE;
            end
          end else begin
            // age entries, then make the written slot newest
            for (int i = 0; i < DEPTH; i++) begin
              if (res.found) begin
                if (valid[i] && rank[i] < hit_rank) begin
                  rank[i] <= IW'(rank[i] + IW'(1));
                end
              end else if (valid[i] && IW'(i) != slot) begin
                rank[i] <= IW'(rank[i] + IW'(1));
              end
            end
            rank[slot]  <= '0;
            valid[slot] <= 1'b1;
            if (!res.found && !full) begin
              occ <= CW'(occ + CW'(1));
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occ))
    else $error("occupancy count differs from number of valid entries");

  a_free_slot_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && cmd_q == CMD_SET && !res.found && !full) |-> res.free_found)
    else $error("insert without a free slot");

  a_oldest_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && cmd_q == CMD_SET && !res.found && full) |-> res.old_found)
    else $error("eviction without an oldest entry");

  a_result_from_get: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_UPD && cmd_q == CMD_GET))
    else $error("result raised outside a get update");

endmodule

FILE: rtl/kvc_store.sv
// kvc_store: key and value memories, one write and one registered read a cycle
// depends on kvc_pkg
module kvc_store #(
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  kvc_pkg::word_t                          wkey,
  input  kvc_pkg::word_t                          wval,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output kvc_pkg::word_t                          rkey,
  output kvc_pkg::word_t                          rval
);
  import kvc_pkg::*;

  word_t keys_mem [DEPTH];
  word_t vals_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      keys_mem[waddr] <= wkey;
      vals_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= keys_mem[raddr];
    rval <= vals_mem[raddr];
  end

endmodule

FILE: rtl/kvc_scan.sv
// kvc_scan: shared compare unit, checks one stored entry a cycle while cmp_en is high
// tracks key match, oldest entry and first free slot; depends on kvc_pkg
module kvc_scan #(
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  kvc_pkg::scan_ctl_t                      ctl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] idx,
  input  kvc_pkg::word_t                          key,
  input  kvc_pkg::word_t                          rd_key,
  input  kvc_pkg::word_t                          rd_val,
  input  logic                                    valid_at,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rank_at,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] old_rank,
  output kvc_pkg::scan_res_t                      res,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] hit_idx,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] hit_rank,
  output kvc_pkg::word_t                          hit_val,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] old_idx,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] free_idx
);
  import kvc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      res <= '0;
    end else if (ctl.cmp_en) begin
      if (valid_at && rd_key == key && !res.found) begin
        res.found <= 1'b1;
        hit_idx   <= idx;
        hit_rank  <= rank_at;
        hit_val   <= rd_val;
      end
      if (valid_at && rank_at == old_rank) begin
        res.old_found <= 1'b1;
        old_idx       <= idx;
      end
      if (!valid_at && !res.free_found) begin
        res.free_found <= 1'b1;
        free_idx       <= idx;
      end
    end
  end

endmodule
